FILE: src/me_pkg.sv
// Shared constants and controller/datapath interface types for the modular exponentiation block.
package me_pkg;

    // Operand widths: modulus and base share MOD_BITS, the exponent uses EXP_BITS.
    localparam int MOD_BITS = 31;
    localparam int EXP_BITS = 63;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W  = ((MOD_BITS + EXP_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

    // Step counter for one bit-serial modular multiplication.
    localparam int CNT_W = $clog2(MOD_BITS);

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(64'd1000000007);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture base/exponent, seed accumulator with 1 mod m
        logic mm_clr;    // load multiplier operands, clear partial remainders
        logic mm_step;   // consume one multiplier bit
        logic sel_pre;   // square unit computes (1 mod m) * base, i.e. base mod m
        logic sq_write;  // square term takes the reduced base
        logic bit_done;  // square, conditional multiply, shift exponent
        logic out_load;  // move accumulator into the output register
    } me_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;  // no exponent bits left
    } me_status_t;

endpackage

FILE: src/me_mulmod.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per step, MSB first.
module me_mulmod
    import me_pkg::*;
(
    input  logic                clk,
    input  logic                clr,
    input  logic                step,
    input  logic [MOD_BITS-1:0] a,       // must be below m
    input  logic [MOD_BITS-1:0] b,       // any value
    input  logic [MOD_BITS-1:0] m,       // effective modulus, nonzero
    output logic [MOD_BITS-1:0] result
);

    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS+1:0] t;
    logic [MOD_BITS+1:0] m1;
    logic [MOD_BITS+1:0] m2;
    logic [MOD_BITS+1:0] t_red;

    // t = 2r + a*b_i stays below 3m; subtract 0, m or 2m
    always_comb
    begin
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (b_reg[MOD_BITS-1] ? {2'b00, a_reg} : '0);
        if (t >= m2)
        begin
            t_red = t - m2;
        end
        else if (t >= m1)
        begin
            t_red = t - m1;
        end
        else
        begin
            t_red = t;
        end
    end

    always_comb
    begin
        r_next = r_reg;
        a_next = a_reg;
        b_next = b_reg;
        if (clr)
        begin
            r_next = '0;
            a_next = a;
            b_next = b;
        end
        else if (step)
        begin
            r_next = t_red[MOD_BITS-1:0];
            b_next = {b_reg[MOD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign result = r_reg;

endmodule

FILE: src/me_datapath.sv
// Datapath: modulus register, operand registers, two modular multipliers, output register.
module me_datapath
    import me_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  me_cmd_t             cmd,
    output me_status_t          status,
    input  logic                cfg_we,
    input  logic [MOD_BITS-1:0] cfg_data,
    input  logic [IN_W-1:0]     in_data,
    output logic [OUT_W-1:0]    out_data
);

    logic [MOD_BITS-1:0] mod_reg, mod_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] out_reg, out_next;
    logic [MOD_BITS-1:0] m_eff;
    logic [MOD_BITS-1:0] one_mod;
    logic [MOD_BITS-1:0] sq_a;
    logic [MOD_BITS-1:0] sq_prod;
    logic [MOD_BITS-1:0] mul_prod;

    // A zero modulus acts as one
    assign m_eff   = (mod_reg == '0) ? MOD_BITS'(1) : mod_reg;
    assign one_mod = MOD_BITS'(mod_reg > MOD_BITS'(1));

    // Square unit doubles as the base reducer: (1 mod m) * base
    assign sq_a = cmd.sel_pre ? acc_reg : sq_reg;

    me_mulmod u_square
    (
        .clk    (clk),
        .clr    (cmd.mm_clr),
        .step   (cmd.mm_step),
        .a      (sq_a),
        .b      (sq_reg),
        .m      (m_eff),
        .result (sq_prod)
    );

    me_mulmod u_multiply
    (
        .clk    (clk),
        .clr    (cmd.mm_clr),
        .step   (cmd.mm_step),
        .a      (sq_reg),
        .b      (acc_reg),
        .m      (m_eff),
        .result (mul_prod)
    );

    always_comb
    begin
        mod_next = cfg_we ? cfg_data : mod_reg;
        acc_next = acc_reg;
        sq_next  = sq_reg;
        exp_next = exp_reg;
        out_next = cmd.out_load ? acc_reg : out_reg;
        if (cmd.load)
        begin
            sq_next  = in_data[MOD_BITS-1:0];
            exp_next = in_data[MOD_BITS +: EXP_BITS];
            acc_next = one_mod;
        end
        else if (cmd.sq_write)
        begin
            sq_next = sq_prod;
        end
        else if (cmd.bit_done)
        begin
            sq_next  = sq_prod;
            exp_next = exp_reg >> 1;
            if (exp_reg[0])
            begin
                acc_next = mul_prod;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MODULUS_RESET;
        end
        else
        begin
            mod_reg <= mod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        out_reg <= out_next;
    end

    assign status.exp_zero = (exp_reg == '0);
    assign out_data        = OUT_W'(out_reg);

endmodule

FILE: src/me_ctrl.sv
// Controller: sequences base reduction, per-bit multiply passes and the output handoff.
module me_ctrl
    import me_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  me_status_t status,
    output me_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pre_reg, pre_next;
    logic             oval_reg, oval_next;
    logic             out_free;

    assign out_free  = !oval_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pre_next   = pre_reg;
        oval_next  = (oval_reg && out_ready) ? 1'b0 : oval_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pre_next   = 1'b1;
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                cmd.mm_clr  = 1'b1;
                cmd.sel_pre = pre_reg;
                cnt_next    = '0;
                state_next  = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.mm_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (pre_reg)
                begin
                    cmd.sq_write = 1'b1;
                    pre_next     = 1'b0;
                end
                else
                begin
                    cmd.bit_done = 1'b1;
                end
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next = status.exp_zero ? ST_OUT : ST_CLR;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    oval_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pre_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pre_reg   <= pre_next;
            oval_reg  <= oval_next;
        end
    end

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!oval_reg || out_ready))
        else $error("output register overwritten while stalled");

    // An accepted beat always starts with the base-reduction pass
    a_accept_starts_pre: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CLR && pre_reg))
        else $error("accepted beat did not start the reduction pass");

    // A multiply pass ends after exactly MOD_BITS steps
    a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && cnt_reg == CNT_LAST) |=> (state_reg == ST_UPD))
        else $error("multiply pass did not end on the last step");

    // Multiplier steps only run inside a pass
    a_step_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mm_step |-> $past(state_reg == ST_CLR || state_reg == ST_STEP))
        else $error("multiplier step outside a pass");

endmodule

FILE: src/modular_exponentiation.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
// Channels:
//   s_*   input beats: base and exponent. Taken only while the block is idle.
//   m_*   result beats: base^exponent mod modulus, held in an output register.
//   cfg_* modulus write, always ready. Write only while no beat is in flight.
// A modulus of zero acts as one, so every result is then zero.
//
// Timing: every modular product is formed bit-serially, one multiplier bit per
// cycle; a pass runs clear, 31 steps, update and check. One pass reduces the
// base, then one pass per exponent bit up to the highest set one, so L passes
// for an exponent of bit length L; the square and the conditional multiply
// share each pass. The next input beat is taken only once the result has been
// loaded into the output register and the controller is back in idle.
//
// Reset clears the controller and restores the modulus to 1000000007.
// A stalled receiver holds m_tdata; a new input beat is still accepted, and its
// result waits in the accumulator with s_tready low until the output frees.
module modular_exponentiation
    import me_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // [30:0] base, [93:31] exponent, [95:94] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [30:0] power_mod, [31] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MOD_BITS-1:0] cfg_data   // modulus
);

    me_cmd_t    cmd;
    me_status_t status;

    // The modulus register takes a write in any cycle
    assign cfg_ready = 1'b1;

    me_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    me_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

FILE: dv/power_mod_checker.sv
`timescale 1ns / 100ps
// Monitor that predicts base^exponent mod modulus for every input beat and checks result beats.
module power_mod_checker
    import me_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // [30:0] base, [93:31] exponent, [95:94] zero
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,   // [30:0] power_mod, [31] zero
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [MOD_BITS-1:0] cfg_data,  // modulus
    output int                  mismatches,
    output int                  pending,
    output int                  results_seen
);

    typedef struct {
        int unsigned         item;
        logic [MOD_BITS-1:0] power_mod;
    } power_expect_t;

    power_expect_t       expected_powers[$];
    power_expect_t       oldest;
    power_expect_t       incoming;
    logic [MOD_BITS-1:0] modulus_copy;
    logic [MOD_BITS-1:0] got_power;
    int unsigned         items_taken;
    int                  fail_count;
    int                  result_count;

    // Right-to-left square-and-multiply; a zero modulus acts as one.
    function automatic logic [MOD_BITS-1:0] expected_power(
        input logic [MOD_BITS-1:0] base,
        input logic [EXP_BITS-1:0] exponent,
        input logic [MOD_BITS-1:0] modulus
    );
        logic [63:0]         m;
        logic [63:0]         acc;
        logic [63:0]         sq;
        logic [EXP_BITS-1:0] e;
        m   = (modulus == '0) ? 64'd1 : 64'(modulus);
        sq  = 64'(base) % m;
        acc = 64'd1 % m;
        e   = exponent;
        while (e != '0)
        begin
            if (e[0])
                acc = (acc * sq) % m;
            e  = e >> 1;
            sq = (sq * sq) % m;
        end
        return acc[MOD_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_powers.delete();
            modulus_copy = MODULUS_RESET;
            items_taken  = 0;
            fail_count   = 0;
            result_count = 0;
            mismatches   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_power = m_tdata[MOD_BITS-1:0];
                result_count++;
                if (expected_powers.size() == 0)
                begin
                    $error("result beat 0x%0h arrived with no item outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_powers.pop_front();
                    if (got_power !== oldest.power_mod)
                    begin
                        $error("item %0d power_mod: expected %0d, got %0d",
                               oldest.item, oldest.power_mod, got_power);
                        fail_count++;
                    end
                    if (m_tdata[OUT_W-1:MOD_BITS] !== '0)
                    begin
                        $error("item %0d pad: expected 0, got %0h",
                               oldest.item, m_tdata[OUT_W-1:MOD_BITS]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                incoming.item      = items_taken;
                incoming.power_mod = expected_power(s_tdata[MOD_BITS-1:0],
                                                    s_tdata[MOD_BITS +: EXP_BITS],
                                                    modulus_copy);
                expected_powers.insert(expected_powers.size(), incoming);
                items_taken++;
            end
            if (cfg_valid && cfg_ready)
                modulus_copy = cfg_data;
            mismatches   <= fail_count;
            pending      <= expected_powers.size();
            results_seen <= result_count;
        end
    end

endmodule

FILE: dv/tb_modular_exponentiation.sv
`timescale 1ns / 100ps
// Testbench top for modular_exponentiation: stimulus, flow control and the verdict.
module tb_modular_exponentiation;
    import me_pkg::*;

    // Run shape: a directed block at the reset modulus, then one random phase per
    // entry of the modulus plan. Each phase ends with a full drain so the modulus
    // is only ever rewritten while the block sits idle.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 6;
    // Long receiver hold: far longer than two short items, so the output register
    // and the parked result both fill and the block drops s_tready.
    localparam int LONG_HOLD       = 3000;
    // Quietest correct stretch: the long hold plus one full 63-bit item
    // plus the drain tail; take it several times over.
    localparam int WATCHDOG_LIMIT  = 20000;
    // The tail after a drain spans two modular-product passes, so a stray
    // result beat would still be caught.
    localparam int TAIL_CYCLES     = 2 * (MOD_BITS + 3);

    localparam logic [MOD_BITS-1:0] MOD_MAX = '1;
    localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata     = '0;   // [30:0] base, [93:31] exponent, [95:94] zero
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [OUT_W-1:0]    m_tdata;            // [30:0] power_mod, [31] zero
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [MOD_BITS-1:0] cfg_data    = '0;   // modulus

    // Per-phase flow-control knobs. sink_stalls and pressure_on are read by the
    // receiver process, so they change only through nonblocking updates.
    logic                gaps_on       = 1'b1;
    logic                sink_stalls   = 1'b1;
    logic                pressure_on   = 1'b0;
    logic                pressure_done = 1'b0;

    logic [MOD_BITS-1:0] modulus_now = MODULUS_RESET;
    int                  items_sent  = 0;
    int                  moduli_used = 1;
    int                  quiet_cycles = 0;
    int                  mismatches;
    int                  pending;
    int                  results_seen;

    modular_exponentiation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    power_mod_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sender idle time: mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Cost grows with the highest set exponent bit, so keep most exponents
    // narrow and send full 63-bit ones only now and then.
    function automatic logic [EXP_BITS-1:0] rand_exponent(input logic short_only);
        int          roll;
        int          width;
        logic [63:0] raw;
        roll = $urandom_range(0, 99);
        raw  = {$urandom, $urandom};
        if (short_only)
            width = $urandom_range(0, 8);
        else if (roll < 5)
            width = EXP_BITS;
        else if (roll < 10)
            width = $urandom_range(17, 40);
        else
            width = $urandom_range(0, 16);
        if (width == 0)
            return '0;
        return raw[EXP_BITS-1:0] & (EXP_MAX >> (EXP_BITS - width));
    endfunction

    // Mostly full-range bases; the rest sit on the range edges and around the modulus.
    function automatic logic [MOD_BITS-1:0] rand_base();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return MOD_BITS'(1);
            2:       return modulus_now - 1'b1;
            3:       return modulus_now;
            4:       return modulus_now + 1'b1;
            5:       return MOD_MAX;
            default: return MOD_BITS'($urandom);
        endcase
    endfunction

    // Offer one beat and hold it until accepted. Valid stays high on return so a
    // back-to-back beat follows without a bubble.
    task automatic send_item(input logic [MOD_BITS-1:0] base,
                             input logic [EXP_BITS-1:0] exponent);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {{(IN_W - MOD_BITS - EXP_BITS){1'b0}}, exponent, base};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_modulus(input logic [MOD_BITS-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        modulus_now = value;
        moduli_used++;
    endtask

    // Drop valid, wait out every outstanding result, then idle a little. The
    // first edge lets the checker's count catch up with the last input beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls in most phases, and once a single long hold while
    // the sender keeps offering beats, which backs the block up to its input.
    initial
    begin : sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = 0;
            if (pressure_on && !pressure_done)
            begin
                hold          = LONG_HOLD;
                pressure_done = 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 99) < 30)
                hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no beat accepted for %0d cycles, %0d results outstanding",
                       quiet_cycles, pending);
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [MOD_BITS-1:0] modulus_plan [PHASES];
        int                  directed_items;

        // Extremes first, then the one-and-zero moduli, then a spread of sizes.
        modulus_plan[0] = MOD_MAX;
        modulus_plan[1] = MOD_BITS'(1);
        modulus_plan[2] = '0;                              // acts as a modulus of one
        modulus_plan[3] = MOD_BITS'(2);
        modulus_plan[4] = MOD_BITS'($urandom_range(3, 32'h7fff_ffff));
        modulus_plan[5] = MOD_MAX - 1'b1;                  // largest even modulus
        modulus_plan[6] = MOD_BITS'($urandom_range(3, 1000));
        modulus_plan[7] = MOD_BITS'($urandom_range(32'h4000_0000, 32'h7fff_ffff)) | 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed block at the reset modulus: zero and one bases, the widest
        // fields, bases around the modulus, and a lone top exponent bit.
        send_item('0, '0);
        send_item('0, EXP_BITS'(1));
        send_item('0, EXP_MAX);
        send_item(MOD_BITS'(1), EXP_MAX);
        send_item(MOD_MAX, '0);
        send_item(MOD_MAX, EXP_BITS'(1));
        send_item(MOD_MAX, EXP_BITS'(2));
        send_item(MOD_MAX, EXP_MAX);
        send_item(MODULUS_RESET - 1'b1, EXP_MAX);
        send_item(MODULUS_RESET, EXP_BITS'(5));
        send_item(MODULUS_RESET + 1'b1, EXP_BITS'(12345));
        send_item(MOD_BITS'(2), EXP_BITS'(62));
        send_item(MOD_BITS'(3), EXP_MAX ^ (EXP_MAX >> 1));
        send_item(MOD_BITS'(7), EXP_BITS'(MODULUS_RESET - 2));
        send_item(MOD_BITS'(2), EXP_BITS'(MODULUS_RESET - 1));
        repeat (3) send_item(MOD_BITS'($urandom), rand_exponent(1'b0));
        directed_items = items_sent;
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_modulus(modulus_plan[p]);
            gaps_on     = (p % 3) != 1;
            sink_stalls <= (p % 4) != 2;
            pressure_on <= (p == PRESSURE_PHASE);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(rand_base(), rand_exponent(p == PRESSURE_PHASE));
            drain();
        end

        $display("Run covered %0d items (%0d directed) under %0d modulus settings, %0d results",
                 items_sent, directed_items, moduli_used, results_seen);
        $display("including moduli 0, 1, 2 and 2^31-1, 63-bit exponents and a long output stall");
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
